// ===== rtl/lrsc_pkg.sv =====
`timescale 1ns / 1ps
package lrsc_pkg;

  localparam int NUM_SLOTS_DEF = 10;
  localparam int TAG_BITS_DEF  = 16;
  localparam int AGE_BITS_DEF  = 16;
  localparam int PIN_BITS_DEF  = 2;

  // fixed field widths of the channels
  localparam int REQ_W  = 3;
  localparam int LOC_W  = 16;
  localparam int SLOT_W = 4;
  localparam int ERR_W  = 3;

  localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SPILL  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REINIT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_SLOT = 3'd1;
  localparam logic [ERR_W-1:0] ERR_FREE    = 3'd2;
  localparam logic [ERR_W-1:0] ERR_PINNED  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_REQ = 3'd4;

  // per-slot verdict of the compare unit
  typedef struct packed {
    logic match;
    logic pinned;
    logic take;
  } lrsc_cmp_t;

endpackage

// ===== rtl/lrsc_if.sv =====
`timescale 1ns / 1ps
interface lrsc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lrsc_pkg::REQ_W-1:0]  req_type;
  logic [lrsc_pkg::LOC_W-1:0]  location_tag;
  logic                        want_fill;
  logic [lrsc_pkg::SLOT_W-1:0] slot_index;
  logic                        mark_dirty;

  modport source (output valid, req_type, location_tag, want_fill, slot_index, mark_dirty,
                  input ready);
  modport sink (input valid, req_type, location_tag, want_fill, slot_index, mark_dirty,
                output ready);
endinterface

interface lrsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lrsc_pkg::SLOT_W-1:0] slot_out;
  logic                        hit;
  logic                        spill_valid;
  logic [lrsc_pkg::LOC_W-1:0]  spill_tag;
  logic                        fill_valid;
  logic [lrsc_pkg::ERR_W-1:0]  error_code;
  logic                        last;

  modport source (output valid, slot_out, hit, spill_valid, spill_tag, fill_valid,
                  error_code, last, input ready);
  modport sink (input valid, slot_out, hit, spill_valid, spill_tag, fill_valid,
                error_code, last, output ready);
endinterface

// ===== rtl/lrsc_cmp.sv =====
`timescale 1ns / 1ps
module lrsc_cmp #(
  parameter int TAG_BITS = lrsc_pkg::TAG_BITS_DEF,
  parameter int AGE_BITS = lrsc_pkg::AGE_BITS_DEF,
  parameter int PIN_BITS = lrsc_pkg::PIN_BITS_DEF
) (
  input  logic                slot_valid,
  input  logic [TAG_BITS-1:0] slot_tag,
  input  logic [TAG_BITS-1:0] req_tag,
  input  logic [PIN_BITS-1:0] slot_pins,
  input  logic                slot_dirty,
  input  logic [AGE_BITS-1:0] slot_age,
  input  logic                best_found,
  input  logic                best_dirty,
  input  logic [AGE_BITS-1:0] best_age,
  output lrsc_pkg::lrsc_cmp_t res
);
  import lrsc_pkg::*;

  logic better;

  // clean beats dirty, then strictly older wins so ties keep the lower index
  always_comb begin
    if (slot_dirty != best_dirty) begin
      better = !slot_dirty;
    end else begin
      better = slot_age < best_age;
    end
  end

  always_comb begin
    res.match  = slot_valid && (slot_tag == req_tag);
    res.pinned = slot_pins != '0;
    res.take   = !res.pinned && (!best_found || better);
  end

endmodule

// ===== rtl/lru_register_shadow_cache.sv =====
`timescale 1ns / 1ps
// allocate, query and spill-all scan one slot per cycle through a shared compare unit:
//   the result is registered from the finish state after the last slot, once the output is free
// spill-all then gives one result per dirty slot, at most one per cycle, in index order
// free, reinit and unknown requests register their result from the free or error state
// a new request is taken once the previous one has handed its last result to the output register
// synchronous active-low reset: all slots invalid, clean, unpinned, age zero, age counter one
module lru_register_shadow_cache #(
  parameter int NUM_SLOTS = lrsc_pkg::NUM_SLOTS_DEF,
  parameter int TAG_BITS  = lrsc_pkg::TAG_BITS_DEF,
  parameter int AGE_BITS  = lrsc_pkg::AGE_BITS_DEF,
  parameter int PIN_BITS  = lrsc_pkg::PIN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lrsc_in_if.sink    in_ch,
  lrsc_out_if.source out_ch
);
  import lrsc_pkg::*;

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FIN   = 6'b000100,
    S_FREE  = 6'b001000,
    S_SPILL = 6'b010000,
    S_ERR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // slot pool
  logic [TAG_BITS-1:0]  tag_r   [NUM_SLOTS];
  logic [TAG_BITS-1:0]  tag_nxt [NUM_SLOTS];
  logic [AGE_BITS-1:0]  age_r   [NUM_SLOTS];
  logic [AGE_BITS-1:0]  age_nxt [NUM_SLOTS];
  logic [PIN_BITS-1:0]  pins_r  [NUM_SLOTS];
  logic [PIN_BITS-1:0]  pins_nxt[NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0] dirty_r, dirty_nxt;
  logic [AGE_BITS-1:0]  age_cnt_r, age_cnt_nxt;

  // request
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [TAG_BITS-1:0] rtag_r, rtag_nxt;
  logic                fill_r, fill_nxt;
  logic                mdirty_r, mdirty_nxt;
  logic [ERR_W-1:0]    err_r, err_nxt;

  // scan
  logic [IW-1:0]       ptr_r, ptr_nxt;
  logic                hit_r, hit_nxt;
  logic [IW-1:0]       hidx_r, hidx_nxt;
  logic                vfound_r, vfound_nxt;
  logic [IW-1:0]       vidx_r, vidx_nxt;
  logic                vdirty_r, vdirty_nxt;
  logic [AGE_BITS-1:0] vage_r, vage_nxt;
  logic                pin_any_r, pin_any_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic [SLOT_W-1:0] o_slot_r, o_slot_nxt;
  logic              o_hit_r, o_hit_nxt;
  logic              o_sv_r, o_sv_nxt;
  logic [LOC_W-1:0]  o_st_r, o_st_nxt;
  logic              o_fv_r, o_fv_nxt;
  logic [ERR_W-1:0]  o_err_r, o_err_nxt;
  logic              o_last_r, o_last_nxt;

  logic                  in_fire, out_free, emit;
  logic [AGE_BITS-1:0]   stamp;
  logic [SLOT_W+IW-1:0]  idx_ext;
  logic [SLOT_W+IW-1:0]  ptr_ext;
  logic [LOC_W+TAG_BITS-1:0] loc_ext;
  logic [LOC_W+TAG_BITS-1:0] tag_ext;
  lrsc_cmp_t             cmp;

  lrsc_cmp #(
    .TAG_BITS(TAG_BITS),
    .AGE_BITS(AGE_BITS),
    .PIN_BITS(PIN_BITS)
  ) u_cmp (
    .slot_valid(valid_r[ptr_r]),
    .slot_tag  (tag_r[ptr_r]),
    .req_tag   (rtag_r),
    .slot_pins (pins_r[ptr_r]),
    .slot_dirty(dirty_r[ptr_r]),
    .slot_age  (age_r[ptr_r]),
    .best_found(vfound_r),
    .best_dirty(vdirty_r),
    .best_age  (vage_r),
    .res       (cmp)
  );

  assign in_ch.ready = state_r == S_IDLE;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !ov_r || out_ch.ready;
  assign stamp       = age_cnt_r;
  assign idx_ext     = {{IW{1'b0}}, in_ch.slot_index};
  assign ptr_ext     = {{SLOT_W{1'b0}}, ptr_r};
  assign loc_ext     = {{TAG_BITS{1'b0}}, in_ch.location_tag};
  assign tag_ext     = {{LOC_W{1'b0}}, tag_r[ptr_r]};

  always_comb begin
    state_nxt   = state_r;
    tag_nxt     = tag_r;
    age_nxt     = age_r;
    pins_nxt    = pins_r;
    valid_nxt   = valid_r;
    dirty_nxt   = dirty_r;
    age_cnt_nxt = age_cnt_r;
    req_nxt     = req_r;
    rtag_nxt    = rtag_r;
    fill_nxt    = fill_r;
    mdirty_nxt  = mdirty_r;
    err_nxt     = err_r;
    ptr_nxt     = ptr_r;
    hit_nxt     = hit_r;
    hidx_nxt    = hidx_r;
    vfound_nxt  = vfound_r;
    vidx_nxt    = vidx_r;
    vdirty_nxt  = vdirty_r;
    vage_nxt    = vage_r;
    pin_any_nxt = pin_any_r;
    cnt_nxt     = cnt_r;
    emit        = 1'b0;
    o_slot_nxt  = '0;
    o_hit_nxt   = 1'b0;
    o_sv_nxt    = 1'b0;
    o_st_nxt    = '0;
    o_fv_nxt    = 1'b0;
    o_err_nxt   = ERR_OK;
    o_last_nxt  = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt     = in_ch.req_type;
          rtag_nxt    = loc_ext[TAG_BITS-1:0];
          fill_nxt    = in_ch.want_fill;
          mdirty_nxt  = in_ch.mark_dirty;
          ptr_nxt     = '0;
          hit_nxt     = 1'b0;
          vfound_nxt  = 1'b0;
          pin_any_nxt = 1'b0;
          cnt_nxt     = '0;
          unique case (in_ch.req_type) inside
            REQ_ALLOC, REQ_QUERY, REQ_SPILL: begin
              state_nxt = S_SCAN;
            end
            REQ_FREE: begin
              if (32'(in_ch.slot_index) < NUM_SLOTS) begin
                ptr_nxt   = idx_ext[IW-1:0];
                state_nxt = S_FREE;
              end else begin
                err_nxt   = ERR_FREE;
                state_nxt = S_ERR;
              end
            end
            REQ_REINIT: begin
              valid_nxt   = '0;
              dirty_nxt   = '0;
              age_cnt_nxt = AGE_BITS'(1);
              for (int i = 0; i < NUM_SLOTS; i++) begin
                pins_nxt[i] = '0;
                age_nxt[i]  = '0;
              end
              err_nxt   = ERR_OK;
              state_nxt = S_ERR;
            end
            default: begin
              err_nxt   = ERR_BAD_REQ;
              state_nxt = S_ERR;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (cmp.match && !hit_r) begin
          hit_nxt  = 1'b1;
          hidx_nxt = ptr_r;
        end
        if (cmp.take) begin
          vfound_nxt = 1'b1;
          vidx_nxt   = ptr_r;
          vdirty_nxt = dirty_r[ptr_r];
          vage_nxt   = age_r[ptr_r];
        end
        pin_any_nxt = pin_any_r | cmp.pinned;
        cnt_nxt     = cnt_r + CW'(dirty_r[ptr_r]);
        if (ptr_r == IW'(NUM_SLOTS - 1)) begin
          state_nxt = S_FIN;
          if (req_r == REQ_SPILL) begin
            ptr_nxt = '0;
          end else if (hit_nxt || req_r == REQ_QUERY) begin
            ptr_nxt = hidx_nxt;
          end else begin
            ptr_nxt = vidx_nxt;
          end
        end else begin
          ptr_nxt = ptr_r + IW'(1);
        end
      end

      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          emit      = 1'b1;
          case (req_r)
            REQ_ALLOC: begin
              if (hit_r) begin
                if (pins_r[ptr_r] != '1) begin
                  pins_nxt[ptr_r] = pins_r[ptr_r] + PIN_BITS'(1);
                end
                age_nxt[ptr_r] = stamp;
                o_slot_nxt     = ptr_ext[SLOT_W-1:0];
                o_hit_nxt      = 1'b1;
              end else if (vfound_r) begin
                o_slot_nxt       = ptr_ext[SLOT_W-1:0];
                o_sv_nxt         = dirty_r[ptr_r] && valid_r[ptr_r];
                o_st_nxt         = o_sv_nxt ? tag_ext[LOC_W-1:0] : '0;
                o_fv_nxt         = fill_r;
                tag_nxt[ptr_r]   = rtag_r;
                valid_nxt[ptr_r] = 1'b1;
                dirty_nxt[ptr_r] = 1'b0;
                pins_nxt[ptr_r]  = PIN_BITS'(1);
                age_nxt[ptr_r]   = stamp;
              end else begin
                o_err_nxt = ERR_NO_SLOT;
              end
            end
            REQ_QUERY: begin
              if (hit_r) begin
                o_slot_nxt = ptr_ext[SLOT_W-1:0];
                o_hit_nxt  = 1'b1;
              end
            end
            default: begin
              // spill-all: pins block it, nothing dirty gives one empty result
              if (pin_any_r) begin
                o_err_nxt = ERR_PINNED;
              end else if (cnt_r != '0) begin
                emit      = 1'b0;
                state_nxt = S_SPILL;
              end
            end
          endcase
          if (hit_r || vfound_r) begin
            if (req_r == REQ_ALLOC && age_cnt_r != '1) begin
              age_cnt_nxt = age_cnt_r + AGE_BITS'(1);
            end
          end
        end
      end

      S_SPILL: begin
        if (dirty_r[ptr_r]) begin
          if (out_free) begin
            emit             = 1'b1;
            o_slot_nxt       = ptr_ext[SLOT_W-1:0];
            o_sv_nxt         = 1'b1;
            o_st_nxt         = tag_ext[LOC_W-1:0];
            o_last_nxt       = cnt_r == CW'(1);
            dirty_nxt[ptr_r] = 1'b0;
            age_nxt[ptr_r]   = stamp;
            if (age_cnt_r != '1) begin
              age_cnt_nxt = age_cnt_r + AGE_BITS'(1);
            end
            cnt_nxt = cnt_r - CW'(1);
            ptr_nxt = ptr_r + IW'(1);
            if (cnt_r == CW'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          ptr_nxt = ptr_r + IW'(1);
        end
      end

      S_FREE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (pins_r[ptr_r] == '0) begin
            o_err_nxt = ERR_FREE;
          end else begin
            dirty_nxt[ptr_r] = dirty_r[ptr_r] | mdirty_r;
            age_nxt[ptr_r]   = stamp;
            if (age_cnt_r != '1) begin
              age_cnt_nxt = age_cnt_r + AGE_BITS'(1);
            end
            pins_nxt[ptr_r] = pins_r[ptr_r] - PIN_BITS'(1);
            o_slot_nxt      = ptr_ext[SLOT_W-1:0];
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          emit      = 1'b1;
          o_err_nxt = err_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ov_r      <= 1'b0;
      valid_r   <= '0;
      dirty_r   <= '0;
      age_cnt_r <= AGE_BITS'(1);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pins_r[i] <= '0;
        age_r[i]  <= '0;
      end
      ptr_r     <= '0;
      hit_r     <= 1'b0;
      vfound_r  <= 1'b0;
      pin_any_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      valid_r   <= valid_nxt;
      dirty_r   <= dirty_nxt;
      age_cnt_r <= age_cnt_nxt;
      pins_r    <= pins_nxt;
      age_r     <= age_nxt;
      ptr_r     <= ptr_nxt;
      hit_r     <= hit_nxt;
      vfound_r  <= vfound_nxt;
      pin_any_r <= pin_any_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r    <= tag_nxt;
    req_r    <= req_nxt;
    rtag_r   <= rtag_nxt;
    fill_r   <= fill_nxt;
    mdirty_r <= mdirty_nxt;
    err_r    <= err_nxt;
    hidx_r   <= hidx_nxt;
    vidx_r   <= vidx_nxt;
    vdirty_r <= vdirty_nxt;
    vage_r   <= vage_nxt;
    if (emit) begin
      o_slot_r <= o_slot_nxt;
      o_hit_r  <= o_hit_nxt;
      o_sv_r   <= o_sv_nxt;
      o_st_r   <= o_st_nxt;
      o_fv_r   <= o_fv_nxt;
      o_err_r  <= o_err_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.slot_out    = o_slot_r;
  assign out_ch.hit         = o_hit_r;
  assign out_ch.spill_valid = o_sv_r;
  assign out_ch.spill_tag   = o_st_r;
  assign out_ch.fill_valid  = o_fv_r;
  assign out_ch.error_code  = o_err_r;
  assign out_ch.last        = o_last_r;

`ifndef ASSERT_OFF
  a_age_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    age_cnt_r != '0)
    else $error("age counter reached zero");

  a_spill_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPILL |-> cnt_r != '0)
    else $error("spill pass running with no dirty slot left");

  a_pinned_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pins_r[ptr_r] != '0 |-> valid_r[ptr_r])
    else $error("pinned slot holds no tag");

  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dirty_r[ptr_r] |-> valid_r[ptr_r])
    else $error("dirty slot holds no tag");

  a_mid_spill: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !o_last_r |-> state_r == S_SPILL)
    else $error("non-final result outside the spill pass");
`endif

endmodule

// ===== dv/lru_register_shadow_cache_test.sv =====
`timescale 1ns / 1ps
module lru_register_shadow_cache_test;
  import lrsc_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int POOL_SIZE = 12;
  localparam logic [PIN_BITS_DEF-1:0] PIN_MAX = '1;
  localparam logic [AGE_BITS_DEF-1:0] AGE_MAX = '1;
  // request codes the block does not define
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 3'd7;
  localparam logic [SLOT_W-1:0] SLOT_INDEX_MAX = '1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              hit;
    logic              spill_valid;
    logic [LOC_W-1:0]  spill_tag;
    logic              fill_valid;
    logic [ERR_W-1:0]  error_code;
    logic              last;
  } cache_res_t;

  logic clk = 1'b0;
  logic rst_n;

  lrsc_in_if  in_ch ();
  lrsc_out_if out_ch ();

  lru_register_shadow_cache DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the slot pool
  logic [TAG_BITS_DEF-1:0] shadow_tag   [SLOTS];
  logic                    shadow_held  [SLOTS];
  logic                    shadow_dirty [SLOTS];
  logic [PIN_BITS_DEF-1:0] shadow_pins  [SLOTS];
  logic [AGE_BITS_DEF-1:0] shadow_age   [SLOTS];
  logic [AGE_BITS_DEF-1:0] age_now;

  cache_res_t       awaited_results [$];
  cache_res_t       oldest;
  logic [LOC_W-1:0] tag_pool [POOL_SIZE];

  int errors = 0;
  int reqs_sent = 0;
  int results_seen = 0;
  int spills_seen = 0;
  int send_gap_max = 19;
  int recv_gap_max = 19;
  int hold_cycles = 0;

  task automatic clear_shadow();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i]   = '0;
      shadow_held[i]  = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_pins[i]  = '0;
      shadow_age[i]   = '0;
    end
    age_now = AGE_BITS_DEF'(1);
  endtask

  function logic [AGE_BITS_DEF-1:0] take_stamp();
    logic [AGE_BITS_DEF-1:0] s;
    s = age_now;
    if (age_now != AGE_MAX) age_now = age_now + 1'b1;
    return s;
  endfunction

  function automatic int find_slot(logic [LOC_W-1:0] tag);
    for (int i = 0; i < SLOTS; i++)
      if (shadow_held[i] && shadow_tag[i] == tag[TAG_BITS_DEF-1:0]) return i;
    return -1;
  endfunction

  // unpinned only: clean before dirty, then oldest, ties to lowest index
  function automatic int pick_victim();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_pins[i] != 0) continue;
      if (best < 0) begin
        best = i;
      end else if (shadow_dirty[i] != shadow_dirty[best]) begin
        if (!shadow_dirty[i]) best = i;
      end else if (shadow_age[i] < shadow_age[best]) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic cache_res_t make_res(int slot, logic hit, logic spill,
                                          logic [LOC_W-1:0] old_tag, logic fill,
                                          logic [ERR_W-1:0] err, logic last);
    cache_res_t r;
    r.slot_out    = slot[SLOT_W-1:0];
    r.hit         = hit;
    r.spill_valid = spill;
    r.spill_tag   = old_tag;
    r.fill_valid  = fill;
    r.error_code  = err;
    r.last        = last;
    return r;
  endfunction

  task automatic predict_responses(input logic [REQ_W-1:0] kind, input logic [LOC_W-1:0] tag,
                                   input logic fill, input logic [SLOT_W-1:0] idx,
                                   input logic dirty);
    int s;
    int n;
    int k;
    logic spill;
    logic [LOC_W-1:0] old_tag;
    case (kind)
      REQ_ALLOC: begin
        s = find_slot(tag);
        if (s >= 0) begin
          if (shadow_pins[s] != PIN_MAX) shadow_pins[s] = shadow_pins[s] + 1'b1;
          shadow_age[s] = take_stamp();
          awaited_results.push_back(make_res(s, 1'b1, 1'b0, '0, 1'b0, ERR_OK, 1'b1));
        end else begin
          s = pick_victim();
          if (s < 0) begin
            awaited_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, ERR_NO_SLOT, 1'b1));
          end else begin
            spill = shadow_dirty[s] && shadow_held[s];
            old_tag = spill ? shadow_tag[s] : '0;
            shadow_tag[s]   = tag[TAG_BITS_DEF-1:0];
            shadow_held[s]  = 1'b1;
            shadow_dirty[s] = 1'b0;
            shadow_pins[s]  = PIN_BITS_DEF'(1);
            shadow_age[s]   = take_stamp();
            awaited_results.push_back(make_res(s, 1'b0, spill, old_tag, fill, ERR_OK, 1'b1));
          end
        end
      end
      REQ_FREE: begin
        if (idx >= SLOTS || shadow_pins[idx] == 0) begin
          awaited_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, ERR_FREE, 1'b1));
        end else begin
          if (dirty) shadow_dirty[idx] = 1'b1;
          shadow_age[idx]  = take_stamp();
          shadow_pins[idx] = shadow_pins[idx] - 1'b1;
          awaited_results.push_back(make_res(int'(idx), 1'b0, 1'b0, '0, 1'b0, ERR_OK, 1'b1));
        end
      end
      REQ_SPILL: begin
        n = 0;
        s = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_pins[i] != 0) s = i;
          if (shadow_dirty[i]) n++;
        end
        if (s >= 0) begin
          awaited_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, ERR_PINNED, 1'b1));
        end else if (n == 0) begin
          awaited_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, ERR_OK, 1'b1));
        end else begin
          k = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (shadow_dirty[i]) begin
              shadow_dirty[i] = 1'b0;
              shadow_age[i] = take_stamp();
              awaited_results.push_back(make_res(i, 1'b0, 1'b1, shadow_tag[i], 1'b0, ERR_OK,
                                                 k == n - 1));
              k++;
            end
          end
        end
      end
      REQ_REINIT: begin
        clear_shadow();
        awaited_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, ERR_OK, 1'b1));
      end
      REQ_QUERY: begin
        s = find_slot(tag);
        if (s >= 0)
          awaited_results.push_back(make_res(s, 1'b1, 1'b0, '0, 1'b0, ERR_OK, 1'b1));
        else
          awaited_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, ERR_OK, 1'b1));
      end
      default: begin
        awaited_results.push_back(make_res(0, 1'b0, 1'b0, '0, 1'b0, ERR_BAD_REQ, 1'b1));
      end
    endcase
  endtask

  // valid stays high after the transaction; the next call either drops it or
  // presents the next request at the following falling edge
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [LOC_W-1:0] tag,
                          input logic fill, input logic [SLOT_W-1:0] idx, input logic dirty);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= kind;
    in_ch.location_tag <= tag;
    in_ch.want_fill    <= fill;
    in_ch.slot_index   <= idx;
    in_ch.mark_dirty   <= dirty;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_responses(kind, tag, fill, idx, dirty);
    reqs_sent++;
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  function logic [LOC_W-1:0] fresh_tag();
    logic [LOC_W-1:0] t;
    t = LOC_W'($urandom);
    tag_pool[$urandom_range(0, POOL_SIZE - 1)] = t;
    return t;
  endfunction

  function logic [LOC_W-1:0] some_tag();
    if ($urandom_range(0, 9) < 7) return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
    return fresh_tag();
  endfunction

  task automatic release_all_pins();
    for (int i = 0; i < SLOTS; i++)
      while (shadow_pins[i] != 0)
        send_req(REQ_FREE, LOC_W'($urandom), 1'($urandom), SLOT_W'(i),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic test_directed_cases();
    send_req(REQ_REINIT, '0, 1'b0, '0, 1'b0);
    send_req(REQ_QUERY, 16'h0000, 1'b0, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h0000, 1'b1, '0, 1'b0);
    send_req(REQ_ALLOC, 16'hFFFF, 1'b0, '0, 1'b0);
    // pin count runs into its maximum
    repeat (3) send_req(REQ_ALLOC, 16'hFFFF, 1'b1, SLOT_INDEX_MAX, 1'b1);
    send_req(REQ_QUERY, 16'hFFFF, 1'b0, '0, 1'b0);
    send_req(REQ_FREE, '0, 1'b0, SLOT_INDEX_MAX, 1'b0);
    send_req(REQ_FREE, '0, 1'b0, 4'd9, 1'b1);
    send_req(REQ_SPILL, '0, 1'b0, '0, 1'b0);
    send_req(REQ_FREE, '0, 1'b0, 4'd0, 1'b1);
    // clean slots go first, then the dirty one with a writeback
    send_req(REQ_ALLOC, 16'h8000, 1'b1, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h7FFF, 1'b0, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h5555, 1'b1, '0, 1'b0);
    send_req(REQ_ALLOC, 16'hAAAA, 1'b0, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h0001, 1'b1, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h1000, 1'b0, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h00F0, 1'b1, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h0F00, 1'b0, '0, 1'b0);
    send_req(REQ_ALLOC, 16'hBEEF, 1'b1, '0, 1'b0);
    send_req(REQ_ALLOC, 16'hCAFE, 1'b1, '0, 1'b0);
    send_req(REQ_UNUSED_FIRST, 16'hFFFF, 1'b1, SLOT_INDEX_MAX, 1'b1);
    send_req(REQ_UNUSED_LAST, '0, 1'b0, '0, 1'b0);
    send_req(REQ_REINIT, '0, 1'b0, '0, 1'b0);
    send_req(REQ_SPILL, '0, 1'b0, '0, 1'b0);
  endtask

  // never-used slots share stamp zero and must go out lowest index first,
  // then writebacks restamp in index order and victims follow that order
  task automatic test_victim_ties();
    send_gap_max = 0;
    recv_gap_max = 0;
    send_req(REQ_REINIT, '0, 1'b0, '0, 1'b0);
    for (int i = 0; i < SLOTS; i++) send_req(REQ_ALLOC, LOC_W'(16'h3000 + i), 1'b0, '0, 1'b0);
    for (int i = 0; i < SLOTS; i++) send_req(REQ_FREE, '0, 1'b0, SLOT_W'(i), 1'b1);
    send_req(REQ_SPILL, '0, 1'b0, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h4000, 1'b1, '0, 1'b0);
    send_req(REQ_FREE, '0, 1'b0, 4'd0, 1'b0);
    send_req(REQ_ALLOC, 16'h4001, 1'b0, '0, 1'b0);
    send_req(REQ_ALLOC, 16'h4002, 1'b1, '0, 1'b0);
    send_req(REQ_REINIT, '0, 1'b0, '0, 1'b0);
    send_gap_max = 19;
    recv_gap_max = 19;
  endtask

  // receiver stalls for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    settle();
    send_gap_max = 0;
    hold_cycles = 300;
    send_req(REQ_ALLOC, fresh_tag(), 1'b1, '0, 1'b0);
    send_req(REQ_ALLOC, fresh_tag(), 1'b0, '0, 1'b0);
    send_req(REQ_QUERY, some_tag(), 1'b0, '0, 1'b0);
    send_req(REQ_FREE, '0, 1'b0, 4'd0, 1'b1);
    send_req(REQ_SPILL, '0, 1'b0, '0, 1'b0);
    release_all_pins();
    send_req(REQ_SPILL, '0, 1'b0, '0, 1'b0);
    send_req(REQ_W'(REQ_UNUSED_FIRST + 1), LOC_W'($urandom), 1'b1, '0, 1'b0);
    settle();
    send_gap_max = 19;
  endtask

  task automatic test_random_traffic();
    int start;
    int iter;
    int pick;
    int pinned [$];
    start = reqs_sent;
    iter = 0;
    while (reqs_sent - start < 180) begin
      if (iter % 25 == 0) begin
        case ((iter / 25) % 3)
          0: begin send_gap_max = 19; recv_gap_max = 19; end
          1: begin send_gap_max = 0;  recv_gap_max = 0;  end
          default: begin send_gap_max = 4; recv_gap_max = 19; end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        send_req(REQ_ALLOC, some_tag(), 1'($urandom), SLOT_W'($urandom), 1'($urandom));
      end else if (pick < 60) begin
        pinned.delete();
        for (int i = 0; i < SLOTS; i++) if (shadow_pins[i] != 0) pinned.push_back(i);
        if (pinned.size() != 0 && $urandom_range(0, 99) < 85)
          send_req(REQ_FREE, LOC_W'($urandom), 1'($urandom),
                   SLOT_W'(pinned[$urandom_range(0, pinned.size() - 1)]), 1'($urandom));
        else
          send_req(REQ_FREE, LOC_W'($urandom), 1'($urandom), SLOT_W'($urandom),
                   1'($urandom));
      end else if (pick < 68) begin
        if ($urandom_range(0, 3) != 0) release_all_pins();
        send_req(REQ_SPILL, LOC_W'($urandom), 1'($urandom), SLOT_W'($urandom), 1'($urandom));
      end else if (pick < 80) begin
        send_req(REQ_QUERY, some_tag(), 1'($urandom), SLOT_W'($urandom), 1'($urandom));
      end else if (pick < 84) begin
        send_req(REQ_REINIT, LOC_W'($urandom), 1'($urandom), SLOT_W'($urandom),
                 1'($urandom));
      end else if (pick < 89) begin
        send_req(REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)), LOC_W'($urandom),
                 1'($urandom), SLOT_W'($urandom), 1'($urandom));
      end else begin
        // burst of new tags to push the pool toward full
        repeat ($urandom_range(3, 6)) send_req(REQ_ALLOC, fresh_tag(), 1'($urandom),
                                               SLOT_W'($urandom), 1'($urandom));
      end
      iter++;
    end
  endtask

  task automatic check_field(input string name, input logic [LOC_W-1:0] want,
                             input logic [LOC_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (out_ch.spill_valid === 1'b1) spills_seen++;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual slot %0h err %0h",
                 $time, out_ch.slot_out, out_ch.error_code);
      end else begin
        oldest = awaited_results.pop_front();
        check_field("slot_out", LOC_W'(oldest.slot_out), LOC_W'(out_ch.slot_out));
        check_field("hit", LOC_W'(oldest.hit), LOC_W'(out_ch.hit));
        check_field("spill_valid", LOC_W'(oldest.spill_valid), LOC_W'(out_ch.spill_valid));
        check_field("spill_tag", oldest.spill_tag, out_ch.spill_tag);
        check_field("fill_valid", LOC_W'(oldest.fill_valid), LOC_W'(out_ch.fill_valid));
        check_field("error_code", LOC_W'(oldest.error_code), LOC_W'(out_ch.error_code));
        check_field("last", LOC_W'(oldest.last), LOC_W'(out_ch.last));
      end
    end
  end

  initial begin
    int idle;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      idle = hold_cycles > 0 ? hold_cycles : $urandom_range(0, recv_gap_max);
      hold_cycles = 0;
      if (idle > 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1) && hold_cycles == 0);
    end
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = '0;
    in_ch.location_tag = '0;
    in_ch.want_fill = 1'b0;
    in_ch.slot_index = '0;
    in_ch.mark_dirty = 1'b0;
    out_ch.ready = 1'b0;
    clear_shadow();
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = LOC_W'($urandom);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_victim_ties();
    test_output_backpressure();
    test_random_traffic();

    settle();
    repeat (3 * SLOTS + 10) @(posedge clk);
    $display("requests %0d, results %0d, writebacks %0d, mismatches %0d", reqs_sent,
             results_seen, spills_seen, errors);
    $display("covered hits, victim order and ties, full pool, pin limit, writebacks, stalls");
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
